[sv/tra_pkg.sv]
// ----------------------------------------------------------------------------
// tra_pkg: shared types and constants for the time range aggregator
// Widths, mode and register codes, and the queue entry carried front to back.
// ----------------------------------------------------------------------------
package tra_pkg;

  localparam int ValueWidth   = 32;
  localparam int TimeWidth    = 63;
  localparam int CountWidth   = 32;
  localparam int SumWidth     = 64;
  localparam int FracBits     = 16;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 64;
  localparam int ModeWidth    = 3;
  localparam int QueueDepth   = 4;
  localparam int QPtrWidth    = $clog2(QueueDepth);
  localparam int QCntWidth    = $clog2(QueueDepth + 1);
  localparam int DivCntWidth  = $clog2(SumWidth);

  localparam logic [CountWidth-1:0] DefaultLimit   = CountWidth'(10000);
  localparam logic [TimeWidth-1:0]  DefaultRangeEnd = {TimeWidth{1'b1}};

  typedef enum logic [ModeWidth-1:0] {
    MODE_COUNT = 3'd0,
    MODE_SUM   = 3'd1,
    MODE_AVG   = 3'd2,
    MODE_MIN   = 3'd3,
    MODE_MAX   = 3'd4,
    MODE_FIRST = 3'd5,
    MODE_LAST  = 3'd6
  } agg_mode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_RANGE_START  = 3'd0,
    CFG_RANGE_END    = 3'd1,
    CFG_RESULT_LIMIT = 3'd2,
    CFG_AGG_MODE     = 3'd3
  } cfg_index_e;

  typedef struct packed {
    logic [TimeWidth-1:0]         point_time;
    logic signed [ValueWidth-1:0] value;
    logic                         match;
    logic                         last;
  } tra_item_t;

endpackage

[sv/time_range_aggregator_core.sv]
// ----------------------------------------------------------------------------
// time_range_aggregator_core: windowed, limited aggregate over a point scan
// Throughput: one point per cycle within a scan while in_stall_o is low.
// Scan end: after the last point leaves the queue, the result is formed in S_SEL
// and registered in S_EMIT; average mode adds a 64-step shift/subtract divider.
// Reset: async active low; registers return to defaults, accumulators clear.
// ----------------------------------------------------------------------------
module time_range_aggregator_core import tra_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [TimeWidth-1:0]         point_time_i,
  input  logic signed [ValueWidth-1:0] sample_value_i,
  input  logic                         last_point_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [CountWidth-1:0]        match_count_o,
  output logic signed [SumWidth-1:0]   agg_value_o,
  output logic [TimeWidth-1:0]         agg_time_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [CfgDataWidth-1:0]      cfg_data_i
);

  logic [TimeWidth-1:0]  range_start_q;
  logic [TimeWidth-1:0]  range_end_q;
  logic [CountWidth-1:0] result_limit_q;
  logic [ModeWidth-1:0]  agg_mode_q;

  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_valid;
  tra_item_t front_item;
  tra_item_t back_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q  <= '0;
      range_end_q    <= DefaultRangeEnd;
      result_limit_q <= DefaultLimit;
      agg_mode_q     <= MODE_COUNT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RANGE_START:  range_start_q  <= cfg_data_i[TimeWidth-1:0];
        CFG_RANGE_END:    range_end_q    <= cfg_data_i[TimeWidth-1:0];
        CFG_RESULT_LIMIT: result_limit_q <= cfg_data_i[CountWidth-1:0];
        CFG_AGG_MODE:     agg_mode_q     <= cfg_data_i[ModeWidth-1:0];
        default:          ;
      endcase
    end
  end

  tra_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .point_time_i   (point_time_i),
    .sample_value_i (sample_value_i),
    .last_point_i   (last_point_i),
    .range_start_i  (range_start_q),
    .range_end_i    (range_end_q),
    .result_limit_i (result_limit_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (front_item)
  );

  tra_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (back_item)
  );

  tra_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (back_item),
    .pop_o         (pop),
    .agg_mode_i    (agg_mode_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .match_count_o (match_count_o),
    .agg_value_o   (agg_value_o),
    .agg_time_o    (agg_time_o)
  );

`ifndef SYNTHESIS
  a_count_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (match_count_o <= result_limit_q))
    else $error("result count above limit");

  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && match_count_o == '0) |-> (agg_value_o == '0 && agg_time_o == '0))
    else $error("empty scan gave nonzero result");

  a_time_only_first_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && agg_time_o != '0) |->
      (agg_mode_q == MODE_FIRST || agg_mode_q == MODE_LAST))
    else $error("timestamp reported in a mode without time");
`endif

endmodule

[sv/tra_front.sv]
// ----------------------------------------------------------------------------
// tra_front: request intake and window/limit classification
// Flags each point as a match and keeps the per-scan match count for the limit.
// ----------------------------------------------------------------------------
module tra_front import tra_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [TimeWidth-1:0]         point_time_i,
  input  logic signed [ValueWidth-1:0] sample_value_i,
  input  logic                         last_point_i,
  input  logic [TimeWidth-1:0]         range_start_i,
  input  logic [TimeWidth-1:0]         range_end_i,
  input  logic [CountWidth-1:0]        result_limit_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output tra_item_t                    item_o
);

  logic [CountWidth-1:0] count_q, count_d;
  logic                  in_window;
  logic                  match;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign in_window = (point_time_i >= range_start_i) && (point_time_i <= range_end_i);
  assign match     = in_window && (count_q < result_limit_i);

  always_comb begin
    item_o.point_time = point_time_i;
    item_o.value      = sample_value_i;
    item_o.match      = match;
    item_o.last       = last_point_i;
  end

  always_comb begin
    count_d = count_q;
    if (push_o) begin
      if (last_point_i) begin
        count_d = '0;
      end else if (match) begin
        count_d = count_q + CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

[sv/tra_queue.sv]
// ----------------------------------------------------------------------------
// tra_queue: short FIFO between classification and accumulation
// Lets the front keep taking points while the back finishes a scan.
// ----------------------------------------------------------------------------
module tra_queue import tra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tra_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output tra_item_t item_o
);

  tra_item_t             mem_q [QueueDepth];
  logic [QPtrWidth-1:0]  wr_ptr_q;
  logic [QPtrWidth-1:0]  rd_ptr_q;
  logic [QCntWidth-1:0]  cnt_q;

  assign full_o  = (cnt_q == QCntWidth'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrWidth'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrWidth'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntWidth'(1);
        2'b01:   cnt_q <= cnt_q - QCntWidth'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[sv/tra_back.sv]
// ----------------------------------------------------------------------------
// tra_back: accumulation, result selection and averaging divider
// Updates count/sum/extreme/first/last per match; emits one result per scan.
// ----------------------------------------------------------------------------
module tra_back import tra_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  tra_item_t                  q_item_i,
  output logic                       pop_o,
  input  logic [ModeWidth-1:0]       agg_mode_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CountWidth-1:0]      match_count_o,
  output logic signed [SumWidth-1:0] agg_value_o,
  output logic [TimeWidth-1:0]       agg_time_o
);

  typedef enum logic [2:0] {
    S_RUN,
    S_SEL,
    S_DIV,
    S_NEG,
    S_EMIT
  } back_state_e;

  back_state_e state_q, state_d;

  logic [CountWidth-1:0]        seen_q, seen_d;
  logic signed [SumWidth-1:0]   total_q, total_d;
  logic signed [ValueWidth-1:0] extreme_q, extreme_d;
  logic signed [ValueWidth-1:0] first_val_q, first_val_d;
  logic [TimeWidth-1:0]         first_time_q, first_time_d;
  logic signed [ValueWidth-1:0] last_val_q, last_val_d;
  logic [TimeWidth-1:0]         last_time_q, last_time_d;

  logic [CountWidth-1:0]        res_count_q, res_count_d;
  logic signed [SumWidth-1:0]   res_value_q, res_value_d;
  logic [TimeWidth-1:0]         res_time_q, res_time_d;

  logic [CountWidth-1:0]        rem_q, rem_d;
  logic [SumWidth-1:0]          quo_q, quo_d;
  logic [DivCntWidth-1:0]       div_cnt_q, div_cnt_d;
  logic                         div_neg_q, div_neg_d;

  logic                         out_valid_q, out_valid_d;
  logic [CountWidth-1:0]        out_count_q, out_count_d;
  logic signed [SumWidth-1:0]   out_value_q, out_value_d;
  logic [TimeWidth-1:0]         out_time_q, out_time_d;

  logic signed [SumWidth-1:0]   ext_v;
  logic signed [SumWidth-1:0]   sum_raw;
  logic                         sum_ovf;
  logic signed [SumWidth-1:0]   sum_sat;
  logic [CountWidth:0]          shifted;
  logic [CountWidth:0]          diff;
  logic                         ge;

  assign pop_o = (state_q == S_RUN) && q_valid_i;

  assign ext_v   = SumWidth'($signed(q_item_i.value));
  assign sum_raw = total_q + ext_v;
  assign sum_ovf = (total_q[SumWidth-1] == ext_v[SumWidth-1])
                && (sum_raw[SumWidth-1] != total_q[SumWidth-1]);
  always_comb begin
    if (!sum_ovf) begin
      sum_sat = sum_raw;
    end else if (total_q[SumWidth-1]) begin
      sum_sat = {1'b1, {(SumWidth-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SumWidth-1){1'b1}}};
    end
  end

  // restoring divide, one quotient bit per cycle; dividend shifts out of quo_q
  assign shifted = {rem_q, quo_q[SumWidth-1]};
  assign diff    = shifted - {1'b0, res_count_q};
  assign ge      = (shifted >= {1'b0, res_count_q});

  always_comb begin
    state_d      = state_q;
    seen_d       = seen_q;
    total_d      = total_q;
    extreme_d    = extreme_q;
    first_val_d  = first_val_q;
    first_time_d = first_time_q;
    last_val_d   = last_val_q;
    last_time_d  = last_time_q;
    res_count_d  = res_count_q;
    res_value_d  = res_value_q;
    res_time_d   = res_time_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    div_cnt_d    = div_cnt_q;
    div_neg_d    = div_neg_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_count_d  = out_count_q;
    out_value_d  = out_value_q;
    out_time_d   = out_time_q;

    case (state_q)
      S_RUN: begin
        if (pop_o) begin
          if (q_item_i.match) begin
            if (seen_q == '0) begin
              extreme_d    = q_item_i.value;
              first_val_d  = q_item_i.value;
              first_time_d = q_item_i.point_time;
            end else if (agg_mode_i == MODE_MIN && q_item_i.value < extreme_q) begin
              extreme_d = q_item_i.value;
            end else if (agg_mode_i == MODE_MAX && extreme_q < q_item_i.value) begin
              extreme_d = q_item_i.value;
            end
            total_d     = sum_sat;
            last_val_d  = q_item_i.value;
            last_time_d = q_item_i.point_time;
            seen_d      = seen_q + CountWidth'(1);
          end
          if (q_item_i.last) begin
            state_d = S_SEL;
          end
        end
      end
      S_SEL: begin
        res_count_d = seen_q;
        res_value_d = '0;
        res_time_d  = '0;
        state_d     = S_EMIT;
        if (seen_q != '0) begin
          case (agg_mode_i)
            MODE_COUNT: res_value_d = SumWidth'({seen_q, {FracBits{1'b0}}});
            MODE_SUM:   res_value_d = total_q;
            MODE_AVG: begin
              rem_d     = '0;
              quo_d     = total_q[SumWidth-1] ? 64'(-total_q) : 64'(total_q);
              div_neg_d = total_q[SumWidth-1];
              div_cnt_d = DivCntWidth'(SumWidth - 1);
              state_d   = S_DIV;
            end
            MODE_MIN,
            MODE_MAX:   res_value_d = SumWidth'(extreme_q);
            MODE_FIRST: begin
              res_value_d = SumWidth'(first_val_q);
              res_time_d  = first_time_q;
            end
            MODE_LAST: begin
              res_value_d = SumWidth'(last_val_q);
              res_time_d  = last_time_q;
            end
            default:    res_value_d = '0;
          endcase
        end
        seen_d       = '0;
        total_d      = '0;
        extreme_d    = '0;
        first_val_d  = '0;
        first_time_d = '0;
        last_val_d   = '0;
        last_time_d  = '0;
      end
      S_DIV: begin
        rem_d = ge ? diff[CountWidth-1:0] : shifted[CountWidth-1:0];
        quo_d = {quo_q[SumWidth-2:0], ge};
        if (div_cnt_q == '0) begin
          state_d = S_NEG;
        end else begin
          div_cnt_d = div_cnt_q - DivCntWidth'(1);
        end
      end
      S_NEG: begin
        res_value_d = div_neg_q ? -$signed(quo_q) : $signed(quo_q);
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_count_d = res_count_q;
          out_value_d = res_value_q;
          out_time_d  = res_time_q;
          state_d     = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_RUN;
      seen_q       <= '0;
      total_q      <= '0;
      extreme_q    <= '0;
      first_val_q  <= '0;
      first_time_q <= '0;
      last_val_q   <= '0;
      last_time_q  <= '0;
      res_count_q  <= '0;
      res_value_q  <= '0;
      res_time_q   <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      div_cnt_q    <= '0;
      div_neg_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_count_q  <= '0;
      out_value_q  <= '0;
      out_time_q   <= '0;
    end else begin
      state_q      <= state_d;
      seen_q       <= seen_d;
      total_q      <= total_d;
      extreme_q    <= extreme_d;
      first_val_q  <= first_val_d;
      first_time_q <= first_time_d;
      last_val_q   <= last_val_d;
      last_time_q  <= last_time_d;
      res_count_q  <= res_count_d;
      res_value_q  <= res_value_d;
      res_time_q   <= res_time_d;
      rem_q        <= rem_d;
      quo_q        <= quo_d;
      div_cnt_q    <= div_cnt_d;
      div_neg_q    <= div_neg_d;
      out_valid_q  <= out_valid_d;
      out_count_q  <= out_count_d;
      out_value_q  <= out_value_d;
      out_time_q   <= out_time_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_count_o = out_count_q;
  assign agg_value_o   = out_value_q;
  assign agg_time_o    = out_time_q;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for time_range_aggregator_core
// Streams scans of (timestamp, value) points under a series of window, limit
// and mode settings. A scoreboard predicts each scan's aggregate and checks
// every result. Handshake gaps and back-pressure vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
  import tra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles   = 100;
  localparam int WatchdogLimit = 5000;
  localparam int RandomPhases  = 10;
  localparam int PhasePoints   = 160;

  localparam logic [CfgIdxWidth-1:0] CfgIdxSpare = 3'd6;
  localparam logic [ModeWidth-1:0]   ModeUnused  = 3'd7;
  localparam logic [TimeWidth-1:0]   TimeMax     = {TimeWidth{1'b1}};
  localparam logic signed [SumWidth-1:0] SumMax  = {1'b0, {(SumWidth-1){1'b1}}};
  localparam logic signed [SumWidth-1:0] SumMin  = {1'b1, {(SumWidth-1){1'b0}}};

  typedef struct {
    logic [TimeWidth-1:0]         stamp;
    logic signed [ValueWidth-1:0] value;
    logic                         last;
  } point_t;

  typedef struct {
    logic [CountWidth-1:0]      count;
    logic signed [SumWidth-1:0] value;
    logic [TimeWidth-1:0]       stamp;
  } aggregate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall_o;
  logic [TimeWidth-1:0]         point_time = '0;
  logic signed [ValueWidth-1:0] sample_value = '0;
  logic                         last_point = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall = 1'b0;
  logic [CountWidth-1:0]        match_count_o;
  logic signed [SumWidth-1:0]   agg_value_o;
  logic [TimeWidth-1:0]         agg_time_o;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready_o;
  logic [CfgIdxWidth-1:0]       cfg_index = '0;
  logic [CfgDataWidth-1:0]      cfg_data = '0;

  time_range_aggregator_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .point_time_i   (point_time),
    .sample_value_i (sample_value),
    .last_point_i   (last_point),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .match_count_o  (match_count_o),
    .agg_value_o    (agg_value_o),
    .agg_time_o     (agg_time_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  point_t     pending_points[$];
  aggregate_t expected_aggregates[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int points_sent    = 0;
  int aggregates_ok  = 0;
  int reg_writes     = 0;
  int phases_run     = 0;
  int quiet_cycles   = 0;
  logic in_taken     = 1'b0;

  // shadow registers and scan accumulators
  logic [TimeWidth-1:0]         win_lo;
  logic [TimeWidth-1:0]         win_hi;
  logic [CountWidth-1:0]        match_cap;
  logic [ModeWidth-1:0]         sel_mode;
  logic [CountWidth-1:0]        scan_count;
  logic signed [SumWidth-1:0]   scan_total;
  logic signed [SumWidth-1:0]   scan_extreme;
  logic signed [SumWidth-1:0]   first_value;
  logic [TimeWidth-1:0]         first_stamp;
  logic signed [SumWidth-1:0]   latest_value;
  logic [TimeWidth-1:0]         latest_stamp;

  function automatic void clear_scan();
    scan_count   = '0;
    scan_total   = '0;
    scan_extreme = '0;
    first_value  = '0;
    first_stamp  = '0;
    latest_value = '0;
    latest_stamp = '0;
  endfunction

  // fold one point into the scan; on the closing point queue the aggregate
  function automatic void accumulate_point(point_t p);
    logic signed [SumWidth-1:0] v64;
    logic signed [SumWidth-1:0] acc;
    logic signed [SumWidth-1:0] divisor;
    aggregate_t res;
    v64 = SumWidth'(p.value);
    if (p.stamp >= win_lo && p.stamp <= win_hi && scan_count < match_cap) begin
      if (scan_count == 0) begin
        scan_extreme = v64;
        first_value  = v64;
        first_stamp  = p.stamp;
      end else if (sel_mode == MODE_MIN && v64 < scan_extreme) begin
        scan_extreme = v64;
      end else if (sel_mode == MODE_MAX && v64 > scan_extreme) begin
        scan_extreme = v64;
      end
      acc = scan_total + v64;
      if (scan_total[SumWidth-1] == v64[SumWidth-1] && acc[SumWidth-1] != scan_total[SumWidth-1])
        acc = scan_total[SumWidth-1] ? SumMin : SumMax;
      scan_total   = acc;
      latest_value = v64;
      latest_stamp = p.stamp;
      scan_count   = scan_count + 1;
    end
    if (p.last) begin
      res.count = scan_count;
      res.value = '0;
      res.stamp = '0;
      if (scan_count != 0) begin
        case (sel_mode)
          MODE_COUNT: res.value = {{(SumWidth-CountWidth-FracBits){1'b0}}, scan_count,
                                   {FracBits{1'b0}}};
          MODE_SUM:   res.value = scan_total;
          MODE_AVG: begin
            divisor   = {{(SumWidth-CountWidth){1'b0}}, scan_count};
            res.value = scan_total / divisor;
          end
          MODE_MIN, MODE_MAX: res.value = scan_extreme;
          MODE_FIRST: begin
            res.value = first_value;
            res.stamp = first_stamp;
          end
          MODE_LAST: begin
            res.value = latest_value;
            res.stamp = latest_stamp;
          end
          default: ;
        endcase
      end
      expected_aggregates.push_back(res);
      clear_scan();
    end
  endfunction

  initial begin
    win_lo    = '0;
    win_hi    = DefaultRangeEnd;
    match_cap = DefaultLimit;
    sel_mode  = MODE_COUNT;
    clear_scan();
  end

  // request driver: new point only once the current one is taken
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        point_t p;
        p = pending_points.pop_front();
        in_valid     <= 1'b1;
        point_time   <= p.stamp;
        sample_value <= p.value;
        last_point   <= p.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      aggregate_t exp_agg;
      point_t p;
      logic active;
      active = 1'b0;
      in_taken <= in_valid && !in_stall_o;
      if (out_valid_o && !out_stall) begin
        active = 1'b1;
        if (expected_aggregates.size() == 0) begin
          $display("%0t: unexpected aggregate count %0d value %h time %h", $time,
                   match_count_o, agg_value_o, agg_time_o);
          errors++;
        end else begin
          exp_agg = expected_aggregates.pop_front();
          if (match_count_o !== exp_agg.count) begin
            $display("%0t: match_count expected %0d got %0d", $time, exp_agg.count,
                     match_count_o);
            errors++;
          end
          if (agg_value_o !== exp_agg.value) begin
            $display("%0t: agg_value expected %h got %h", $time, exp_agg.value, agg_value_o);
            errors++;
          end
          if (agg_time_o !== exp_agg.stamp) begin
            $display("%0t: agg_time expected %h got %h", $time, exp_agg.stamp, agg_time_o);
            errors++;
          end
          aggregates_ok++;
        end
      end
      if (in_valid && !in_stall_o) begin
        active = 1'b1;
        p.stamp = point_time;
        p.value = sample_value;
        p.last  = last_point;
        accumulate_point(p);
        points_sent++;
      end
      if (cfg_valid && cfg_ready_o) begin
        active = 1'b1;
        case (cfg_index)
          CFG_RANGE_START:  win_lo = cfg_data[TimeWidth-1:0];
          CFG_RANGE_END:    win_hi = cfg_data[TimeWidth-1:0];
          CFG_RESULT_LIMIT: match_cap = cfg_data[CountWidth-1:0];
          CFG_AGG_MODE:     sel_mode = cfg_data[ModeWidth-1:0];
          default: ;
        endcase
        reg_writes++;
      end
      quiet_cycles <= active ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
        $display("FAIL time_range_aggregator_core");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_point(input logic [TimeWidth-1:0] stamp,
                           input logic [ValueWidth-1:0] value, input logic last);
    point_t p;
    p.stamp = stamp;
    p.value = value;
    p.last  = last;
    pending_points.push_back(p);
  endtask

  // hold the sender until the block is idle, then allow for its tail latency
  task automatic settle();
    @(posedge clk);
    while (pending_points.size() != 0 || in_valid || expected_aggregates.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [TimeWidth-1:0] pick_stamp(logic [TimeWidth-1:0] lo,
                                                     logic [TimeWidth-1:0] hi);
    logic [TimeWidth-1:0] t;
    t = TimeWidth'({$urandom, $urandom});
    case ($urandom_range(5))
      0: ;
      1: t = lo + TimeWidth'($urandom_range(8)) - TimeWidth'(4);
      2: t = hi + TimeWidth'($urandom_range(8)) - TimeWidth'(4);
      default: begin
        if (hi >= lo && (hi - lo) != TimeMax)
          t = lo + (t % (hi - lo + TimeWidth'(1)));
      end
    endcase
    return t;
  endfunction

  function automatic logic [ValueWidth-1:0] pick_value();
    case ($urandom_range(9))
      0: return {1'b0, {(ValueWidth-1){1'b1}}};
      1: return {1'b1, {(ValueWidth-1){1'b0}}};
      2: return ValueWidth'($urandom_range(16)) - ValueWidth'(8);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int idx);
    logic [TimeWidth-1:0]  lo;
    logic [TimeWidth-1:0]  hi;
    logic [TimeWidth-1:0]  span;
    logic [TimeWidth-1:0]  swap;
    logic [CountWidth-1:0] cap;
    logic [ModeWidth-1:0]  mode;
    int budget;
    int len;
    budget = 0;
    @(posedge clk);
    case (idx % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
    case ($urandom_range(5))
      0: begin lo = '0; hi = TimeMax; end
      1: begin lo = TimeMax - TimeWidth'($urandom_range(64)); hi = TimeMax; end
      2: begin lo = '0; hi = TimeWidth'($urandom_range(64)); end
      default: begin
        lo   = TimeWidth'({$urandom, $urandom});
        span = TimeWidth'($urandom_range(1 << 20));
        hi   = (lo > TimeMax - span) ? TimeMax : lo + span;
      end
    endcase
    if ($urandom_range(11) == 0) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    case ($urandom_range(7))
      0: cap = '1;
      1: cap = DefaultLimit;
      2: cap = '0;
      default: cap = CountWidth'($urandom_range(1, 30));
    endcase
    mode = ModeWidth'($urandom_range(7));
    // upper data bits carry junk; the block must drop them
    write_reg(CFG_RANGE_START, {1'($urandom), lo});
    write_reg(CFG_RANGE_END, {1'($urandom), hi});
    write_reg(CFG_RESULT_LIMIT, {$urandom, cap});
    write_reg(CFG_AGG_MODE, {(CfgDataWidth-ModeWidth)'({$urandom, $urandom}), mode});
    @(posedge clk);
    while (budget < PhasePoints) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++)
        add_point(pick_stamp(lo, hi), pick_value(), i == len - 1);
      budget += len;
    end
    settle();
    phases_run++;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset defaults: full window, count mode, value and time extremes
    add_point('0, {1'b0, {(ValueWidth-1){1'b1}}}, 1'b0);
    add_point(TimeMax, {1'b1, {(ValueWidth-1){1'b0}}}, 1'b0);
    add_point(TimeWidth'({$urandom, $urandom}), '1, 1'b1);
    settle();

    // sum over a narrow window, edges inclusive; then a scan with no match
    write_reg(CFG_AGG_MODE, {{(CfgDataWidth-ModeWidth){1'b0}}, MODE_SUM});
    write_reg(CFG_RANGE_START, 64'd100);
    write_reg(CFG_RANGE_END, 64'd200);
    add_point(63'd99, 32'sd5, 1'b0);
    add_point(63'd100, 32'sd7, 1'b0);
    add_point(63'd200, -32'sd3, 1'b0);
    add_point(63'd201, 32'sd9, 1'b1);
    add_point(63'd50, 32'sd1, 1'b1);
    settle();

    // negative average truncates toward zero
    write_reg(CFG_AGG_MODE, {{(CfgDataWidth-ModeWidth){1'b0}}, MODE_AVG});
    add_point(63'd150, -32'sd7, 1'b0);
    add_point(63'd150, 32'sd2, 1'b1);
    settle();

    // min then max within one scan, limit cuts off the closing point
    write_reg(CFG_RESULT_LIMIT, 64'd3);
    write_reg(CFG_AGG_MODE, {{(CfgDataWidth-ModeWidth){1'b0}}, MODE_MIN});
    add_point(63'd120, 32'sd5, 1'b0);
    add_point(63'd130, -32'sd4, 1'b0);
    settle();
    write_reg(CFG_AGG_MODE, {{(CfgDataWidth-ModeWidth){1'b0}}, MODE_MAX});
    add_point(63'd140, 32'sd9, 1'b0);
    add_point(63'd150, 32'sd1, 1'b1);
    settle();

    // zero limit, then an inverted window
    write_reg(CFG_RESULT_LIMIT, '0);
    write_reg(CFG_AGG_MODE, {{(CfgDataWidth-ModeWidth){1'b1}}, MODE_FIRST});
    add_point(63'd150, 32'sd3, 1'b1);
    settle();
    write_reg(CFG_RESULT_LIMIT, {{(CfgDataWidth-CountWidth){1'b0}}, DefaultLimit});
    write_reg(CFG_RANGE_START, 64'd300);
    write_reg(CFG_AGG_MODE, {{(CfgDataWidth-ModeWidth){1'b0}}, MODE_LAST});
    add_point(63'd250, 32'sd3, 1'b1);
    settle();

    // first, last and the spare mode over the full window
    write_reg(CFG_RANGE_START, 64'd0);
    write_reg(CFG_RANGE_END, '1);
    write_reg(CfgIdxSpare, '1);
    write_reg(CFG_AGG_MODE, {{(CfgDataWidth-ModeWidth){1'b0}}, MODE_FIRST});
    add_point(63'd10, 32'sd4, 1'b0);
    add_point(63'd20, 32'sd8, 1'b1);
    settle();
    write_reg(CFG_AGG_MODE, {{(CfgDataWidth-ModeWidth){1'b0}}, MODE_LAST});
    add_point(63'd30, 32'sd4, 1'b0);
    add_point(63'd40, 32'sd8, 1'b1);
    settle();
    write_reg(CFG_AGG_MODE, {{(CfgDataWidth-ModeWidth){1'b0}}, ModeUnused});
    add_point(63'd5, 32'sd1, 1'b0);
    add_point(63'd6, 32'sd2, 1'b1);
    settle();

    for (int ph = 0; ph < RandomPhases; ph++)
      random_phase(ph);

    $display("Covered %0d points and %0d aggregates, %0d register writes,", points_sent,
             aggregates_ok, reg_writes);
    $display("directed edge scans plus %0d random phases under varied gaps and stalls.",
             phases_run);
    if (errors == 0 && expected_aggregates.size() == 0) begin
      $display("PASS time_range_aggregator_core");
    end else begin
      $display("FAIL time_range_aggregator_core");
    end
    $finish;
  end

endmodule
